// ===== rtl/core/clr_pkg.sv =====
package clr_pkg;

   localparam int SCREEN_W = 320;
   localparam int SCREEN_H = 200;

   localparam logic [15:0] SCREEN_W_ADDR = 16'(SCREEN_W);

   // Q16 constants for the clip parameters and the walk error.
   localparam logic [16:0]        T_ONE    = 17'h10000;
   localparam logic signed [29:0] ERR_ONE  = 30'sd65536;
   localparam logic signed [29:0] ERR_HALF = 30'sd32768;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CSR_CLIP_LEFT   = 2'd0,
      CSR_CLIP_TOP    = 2'd1,
      CSR_CLIP_RIGHT  = 2'd2,
      CSR_CLIP_BOTTOM = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      MODE_IDLE     = 4'b0001,
      MODE_STRAIGHT = 4'b0010,
      MODE_COL      = 4'b0100,
      MODE_ROW      = 4'b1000
   } mode_type;

   typedef struct packed {
      logic               kind;
      logic signed [11:0] x_start;
      logic signed [11:0] y_start;
      logic signed [11:0] x_end;
      logic signed [11:0] y_end;
      logic [23:0]        color;
   } req_type;

   typedef struct packed {
      logic        pixel_valid;
      logic [8:0]  pixel_x;
      logic [7:0]  pixel_y;
      logic [15:0] pixel_address;
      logic [23:0] pixel_color;
      logic        line_done;
   } rsp_type;

   typedef struct packed {
      logic [8:0] clip_left;
      logic [7:0] clip_top;
      logic [8:0] clip_right;
      logic [7:0] clip_bottom;
   } cfg_type;

   typedef struct packed {
      logic               is_start;
      mode_type           mode;
      logic signed [11:0] cur_col;
      logic signed [11:0] cur_row;
      logic signed [11:0] stop_col;
      logic signed [11:0] stop_row;
      logic signed [1:0]  col_dir;
      logic signed [1:0]  row_dir;
      logic [27:0]        err_step;
      logic [23:0]        color;
   } cmd_type;

endpackage

// ===== rtl/core/clr_div.sv =====
module clr_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [13:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [14:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [13:0] den_ff, den_in;
   logic [14:0] shifted;
   logic [15:0] diff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      shifted  = {rem_ff[13:0], quo_ff[31]};
      diff     = {1'b0, shifted} - {2'b00, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         // Restoring division, one quotient bit per cycle.
         if (!diff[15]) begin
            rem_in = diff[14:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/clr_front.sv =====
module clr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  clr_pkg::req_type  req_data,
   input  clr_pkg::cfg_type  cfg,
   output logic              q_push,
   output clr_pkg::cmd_type  q_cmd,
   input  logic              q_full
);

   typedef enum logic [10:0] {
      F_IDLE  = 11'b000_0000_0001,
      F_CLASS = 11'b000_0000_0010,
      F_DSET  = 11'b000_0000_0100,
      F_DGO   = 11'b000_0000_1000,
      F_DWAIT = 11'b000_0001_0000,
      F_MUL   = 11'b000_0010_0000,
      F_RND   = 11'b000_0100_0000,
      F_ESET  = 11'b000_1000_0000,
      F_EGO   = 11'b001_0000_0000,
      F_EWAIT = 11'b010_0000_0000,
      F_PUSH  = 11'b100_0000_0000
   } fstate_type;

   function automatic logic signed [14:0] clamp(input logic signed [14:0] v,
                                                input logic signed [14:0] lo,
                                                input logic signed [14:0] hi);
      logic signed [14:0] res;
      res = v;
      if (res > hi) res = hi;
      if (res < lo) res = lo;
      return res;
   endfunction

   function automatic logic signed [1:0] sgn2(input logic signed [14:0] v);
      logic signed [1:0] res;
      res = 2'sb00;
      if (v > 15'sd0) res = 2'sb01;
      if (v < 15'sd0) res = 2'sb11;
      return res;
   endfunction

   fstate_type         state_ff, state_in;
   logic signed [14:0] x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic signed [14:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [23:0]        color_ff, color_in;
   logic [1:0]         idx_ff, idx_in;
   logic [16:0]        t0_ff, t0_in, t1_ff, t1_in;
   logic               neg_ff, neg_in, pneg_ff, pneg_in;
   logic [31:0]        div_a_ff, div_a_in;
   logic [13:0]        div_d_ff, div_d_in;
   logic signed [31:0] prod_ff, prod_in;
   logic signed [14:0] r_ff [4];
   logic signed [14:0] r_in [4];
   clr_pkg::cmd_type   cmd_ff, cmd_in;

   logic               div_start, div_done;
   logic [31:0]        div_quot;

   logic signed [14:0] l_s, t_s, r_s, b_s;
   logic               clip_empty;
   clr_pkg::cmd_type   step_cmd, rej_cmd;
   logic signed [14:0] p_v, q_v, n_v, ap_v;
   logic [13:0]        den_v;
   logic signed [31:0] num_v;
   logic [31:0]        mag_v;
   logic signed [31:0] rq_v, t0_ext, t1_ext;
   logic signed [31:0] t_ext, d_ext, sum_v;
   logic signed [14:0] base_v, ddx_v, ddy_v, adx_v, ady_v;
   logic signed [14:0] c0_v, r0_v, c1_v, r1_v;

   assign l_s = $signed({6'b0, cfg.clip_left});
   assign t_s = $signed({7'b0, cfg.clip_top});
   assign r_s = $signed({6'b0, cfg.clip_right});
   assign b_s = $signed({7'b0, cfg.clip_bottom});
   assign clip_empty = (cfg.clip_left >= cfg.clip_right) ||
                       (cfg.clip_top >= cfg.clip_bottom);

   // Operands of the current clip boundary ratio.
   always_comb begin
      case (idx_ff)
         2'd0: begin
            p_v = -dx_ff;
            q_v = x0_ff - l_s;
         end
         2'd1: begin
            p_v = dx_ff;
            q_v = r_s - 15'sd1 - x0_ff;
         end
         2'd2: begin
            p_v = -dy_ff;
            q_v = y0_ff - t_s;
         end
         default: begin
            p_v = dy_ff;
            q_v = b_s - 15'sd1 - y0_ff;
         end
      endcase
      n_v   = p_v[14] ? -q_v : q_v;
      ap_v  = p_v[14] ? -p_v : p_v;
      den_v = {ap_v[12:0], 1'b0};
      num_v = $signed({n_v, 17'b0}) + $signed({18'b0, ap_v[13:0]});
      // A negative numerator is floored by rounding its magnitude up.
      mag_v = num_v[31] ? ($unsigned(-num_v) + {18'b0, den_v} - 32'd1)
                        : $unsigned(num_v);
   end

   assign rq_v   = neg_ff ? -$signed(div_quot) : $signed(div_quot);
   assign t0_ext = $signed({15'b0, t0_ff});
   assign t1_ext = $signed({15'b0, t1_ff});
   assign t_ext  = $signed({15'b0, (idx_ff[1] ? t1_ff : t0_ff)});
   assign d_ext  = idx_ff[0] ? $signed({{17{dy_ff[14]}}, dy_ff})
                             : $signed({{17{dx_ff[14]}}, dx_ff});
   assign base_v = idx_ff[0] ? y0_ff : x0_ff;
   assign sum_v  = $signed({base_v[14], base_v, 16'b0}) + prod_ff + 32'sd32768;
   assign ddx_v  = r_ff[2] - r_ff[0];
   assign ddy_v  = r_ff[3] - r_ff[1];
   assign adx_v  = ddx_v[14] ? -ddx_v : ddx_v;
   assign ady_v  = ddy_v[14] ? -ddy_v : ddy_v;

   always_comb begin
      step_cmd          = '0;
      step_cmd.is_start = 1'b0;
      step_cmd.mode     = clr_pkg::MODE_IDLE;
      rej_cmd           = '0;
      rej_cmd.is_start  = 1'b1;
      rej_cmd.mode      = clr_pkg::MODE_IDLE;
      rej_cmd.color     = color_ff;

      state_in  = state_ff;
      x0_in     = x0_ff;
      y0_in     = y0_ff;
      x1_in     = x1_ff;
      y1_in     = y1_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      color_in  = color_ff;
      idx_in    = idx_ff;
      t0_in     = t0_ff;
      t1_in     = t1_ff;
      neg_in    = neg_ff;
      pneg_in   = pneg_ff;
      div_a_in  = div_a_ff;
      div_d_in  = div_d_ff;
      prod_in   = prod_ff;
      r_in      = r_ff;
      cmd_in    = cmd_ff;
      div_start = 1'b0;
      q_push    = 1'b0;
      q_cmd     = step_cmd;
      req_ready = 1'b0;
      c0_v      = x0_ff;
      r0_v      = y0_ff;
      c1_v      = x1_ff;
      r1_v      = y1_ff;

      case (state_ff)
         F_IDLE: begin
            req_ready = !q_full;
            if (req_valid && !q_full) begin
               if (req_data.kind == clr_pkg::KIND_STEP) begin
                  q_push = 1'b1;
               end else begin
                  x0_in    = $signed({{3{req_data.x_start[11]}}, req_data.x_start}) + l_s;
                  y0_in    = $signed({{3{req_data.y_start[11]}}, req_data.y_start}) + t_s;
                  x1_in    = $signed({{3{req_data.x_end[11]}}, req_data.x_end}) + l_s;
                  y1_in    = $signed({{3{req_data.y_end[11]}}, req_data.y_end}) + t_s;
                  color_in = req_data.color;
                  state_in = F_CLASS;
               end
            end
         end
         F_CLASS: begin
            cmd_in   = rej_cmd;
            state_in = F_PUSH;
            if (!clip_empty) begin
               if (x0_ff == x1_ff) begin
                  c0_v = x0_ff;
                  c1_v = x0_ff;
                  r0_v = clamp(y0_ff, t_s, b_s - 15'sd1);
                  r1_v = clamp(y1_ff, t_s, b_s - 15'sd1);
               end else if (y0_ff == y1_ff) begin
                  r0_v = y0_ff;
                  r1_v = y0_ff;
                  c0_v = clamp(x0_ff, l_s, r_s - 15'sd1);
                  c1_v = clamp(x1_ff, l_s, r_s - 15'sd1);
               end
               if ((x0_ff == x1_ff && x0_ff >= l_s && x0_ff < r_s) ||
                   (x0_ff != x1_ff && y0_ff == y1_ff && y0_ff >= t_s && y0_ff < b_s)) begin
                  cmd_in.mode     = clr_pkg::MODE_STRAIGHT;
                  cmd_in.cur_col  = c0_v[11:0];
                  cmd_in.cur_row  = r0_v[11:0];
                  cmd_in.stop_col = c1_v[11:0];
                  cmd_in.stop_row = r1_v[11:0];
                  cmd_in.col_dir  = sgn2(c1_v - c0_v);
                  cmd_in.row_dir  = sgn2(r1_v - r0_v);
               end else if (x0_ff != x1_ff && y0_ff != y1_ff) begin
                  dx_in    = x1_ff - x0_ff;
                  dy_in    = y1_ff - y0_ff;
                  idx_in   = 2'd0;
                  t0_in    = '0;
                  t1_in    = clr_pkg::T_ONE;
                  state_in = F_DSET;
               end
            end
         end
         F_DSET: begin
            div_a_in = mag_v;
            div_d_in = den_v;
            neg_in   = num_v[31];
            pneg_in  = p_v[14];
            state_in = F_DGO;
         end
         F_DGO: begin
            div_start = 1'b1;
            state_in  = F_DWAIT;
         end
         F_DWAIT: begin
            if (div_done) begin
               if ((pneg_ff && rq_v > t1_ext) || (!pneg_ff && rq_v < t0_ext)) begin
                  cmd_in   = rej_cmd;
                  state_in = F_PUSH;
               end else begin
                  if (pneg_ff && rq_v > t0_ext) t0_in = rq_v[16:0];
                  if (!pneg_ff && rq_v < t1_ext) t1_in = rq_v[16:0];
                  idx_in = idx_ff + 2'd1;
                  if (idx_ff == 2'd3) begin
                     state_in = F_MUL;
                  end else begin
                     state_in = F_DSET;
                  end
               end
            end
         end
         F_MUL: begin
            prod_in  = t_ext * d_ext;
            state_in = F_RND;
         end
         F_RND: begin
            r_in[idx_ff] = sum_v[30:16];
            idx_in       = idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               state_in = F_ESET;
            end else begin
               state_in = F_MUL;
            end
         end
         F_ESET: begin
            if (ddx_v == 15'sd0) begin
               cmd_in   = rej_cmd;
               state_in = F_PUSH;
            end else begin
               cmd_in          = rej_cmd;
               cmd_in.mode     = clr_pkg::MODE_COL;
               cmd_in.cur_col  = r_ff[0][11:0];
               cmd_in.cur_row  = r_ff[1][11:0];
               cmd_in.stop_col = r_ff[2][11:0];
               cmd_in.stop_row = r_ff[3][11:0];
               cmd_in.col_dir  = sgn2(ddx_v);
               cmd_in.row_dir  = sgn2(ddy_v);
               div_a_in        = {1'b0, ady_v, 16'b0};
               div_d_in        = adx_v[13:0];
               state_in        = F_EGO;
            end
         end
         F_EGO: begin
            div_start = 1'b1;
            state_in  = F_EWAIT;
         end
         F_EWAIT: begin
            if (div_done) begin
               cmd_in.err_step = div_quot[27:0];
               state_in        = F_PUSH;
            end
         end
         F_PUSH: begin
            q_cmd = cmd_ff;
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff    <= x0_in;
      y0_ff    <= y0_in;
      x1_ff    <= x1_in;
      y1_ff    <= y1_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      color_ff <= color_in;
      idx_ff   <= idx_in;
      t0_ff    <= t0_in;
      t1_ff    <= t1_in;
      neg_ff   <= neg_in;
      pneg_ff  <= pneg_in;
      div_a_ff <= div_a_in;
      div_d_ff <= div_d_in;
      prod_ff  <= prod_in;
      r_ff     <= r_in;
      cmd_ff   <= cmd_in;
   end

   clr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a_ff),
      .divisor  (div_d_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

endmodule

// ===== rtl/core/clr_queue.sv =====
module clr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  clr_pkg::cmd_type push_cmd,
   input  logic             pop,
   output clr_pkg::cmd_type head_cmd,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = $clog2(clr_pkg::QUEUE_DEPTH);

   clr_pkg::cmd_type entry_ff [clr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full     = (count_ff == (PTR_W+1)'(clr_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/clr_back.sv =====
module clr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   output logic             q_pop,
   input  clr_pkg::cmd_type q_cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output clr_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_ADV  = 3'b010,
      B_OUT  = 3'b100
   } bstate_type;

   bstate_type         bstate_ff, bstate_in;
   clr_pkg::mode_type  mode_ff, mode_in;
   logic signed [11:0] cur_col_ff, cur_col_in, cur_row_ff, cur_row_in;
   logic signed [11:0] stop_col_ff, stop_col_in, stop_row_ff, stop_row_in;
   logic signed [1:0]  col_dir_ff, col_dir_in, row_dir_ff, row_dir_in;
   logic signed [29:0] err_acc_ff, err_acc_in;
   logic [27:0]        err_step_ff, err_step_in;
   logic [23:0]        color_ff, color_in;
   logic [23:0]        last_ff, last_in;
   logic signed [11:0] pend_col_ff, pend_col_in, pend_row_ff, pend_row_in;
   logic               drawing_ff, drawing_in;
   logic [1:0]         k_ff, k_in, g_ff, g_in;
   clr_pkg::rsp_type   res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   clr_pkg::rsp_type   rsp_ff, rsp_in;

   logic signed [11:0] col_step, row_step, col_end, row_end;
   logic signed [29:0] err_add, err_sub;
   logic [15:0]        addr_v;
   logic               hit, fail, fin, load;
   logic [23:0]        key;

   assign col_step = cur_col_ff + {{10{col_dir_ff[1]}}, col_dir_ff};
   assign row_step = cur_row_ff + {{10{row_dir_ff[1]}}, row_dir_ff};
   assign col_end  = stop_col_ff + {{10{col_dir_ff[1]}}, col_dir_ff};
   assign row_end  = stop_row_ff + {{10{row_dir_ff[1]}}, row_dir_ff};
   assign err_add  = err_acc_ff + $signed({2'b00, err_step_ff});
   assign err_sub  = err_acc_ff - clr_pkg::ERR_ONE;
   assign addr_v   = {{4{pend_row_ff[11]}}, pend_row_ff} * clr_pkg::SCREEN_W_ADDR
                   + {{4{pend_col_ff[11]}}, pend_col_ff};
   assign key      = {cur_col_ff, cur_row_ff};

   always_comb begin
      bstate_in    = bstate_ff;
      mode_in      = mode_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      stop_col_in  = stop_col_ff;
      stop_row_in  = stop_row_ff;
      col_dir_in   = col_dir_ff;
      row_dir_in   = row_dir_ff;
      err_acc_in   = err_acc_ff;
      err_step_in  = err_step_ff;
      color_in     = color_ff;
      last_in      = last_ff;
      pend_col_in  = pend_col_ff;
      pend_row_in  = pend_row_ff;
      drawing_in   = drawing_ff;
      k_in         = k_ff;
      g_in         = g_ff;
      res_in       = res_ff;
      q_pop        = 1'b0;
      hit          = 1'b0;
      fail         = 1'b0;
      fin          = 1'b0;
      load         = 1'b0;

      case (bstate_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               res_in = '0;
               k_in   = 2'd0;
               g_in   = 2'd0;
               if (q_cmd.is_start) begin
                  // A new line drops whatever was left of the previous one.
                  mode_in     = q_cmd.mode;
                  cur_col_in  = q_cmd.cur_col;
                  cur_row_in  = q_cmd.cur_row;
                  stop_col_in = q_cmd.stop_col;
                  stop_row_in = q_cmd.stop_row;
                  col_dir_in  = q_cmd.col_dir;
                  row_dir_in  = q_cmd.row_dir;
                  err_acc_in  = '0;
                  err_step_in = q_cmd.err_step;
                  color_in    = q_cmd.color;
                  last_in     = '1;
                  drawing_in  = 1'b0;
                  bstate_in   = B_ADV;
               end else if (!drawing_ff) begin
                  res_in.line_done = 1'b1;
                  bstate_in        = B_OUT;
               end else begin
                  res_in.pixel_valid   = 1'b1;
                  res_in.pixel_x       = pend_col_ff[8:0];
                  res_in.pixel_y       = pend_row_ff[7:0];
                  res_in.pixel_address = addr_v;
                  res_in.pixel_color   = color_ff;
                  bstate_in            = B_ADV;
               end
            end
         end
         B_ADV: begin
            // One iteration of the walk per cycle.
            case (mode_ff)
               clr_pkg::MODE_STRAIGHT: begin
                  hit = 1'b1;
                  if (cur_col_ff == stop_col_ff && cur_row_ff == stop_row_ff) begin
                     mode_in = clr_pkg::MODE_IDLE;
                  end else begin
                     cur_col_in = col_step;
                     cur_row_in = row_step;
                  end
               end
               clr_pkg::MODE_COL: begin
                  if (cur_col_ff == col_end) begin
                     mode_in = clr_pkg::MODE_IDLE;
                     fail    = 1'b1;
                  end else begin
                     hit        = 1'b1;
                     err_acc_in = err_add;
                     mode_in    = clr_pkg::MODE_ROW;
                  end
               end
               clr_pkg::MODE_ROW: begin
                  if (err_acc_ff >= clr_pkg::ERR_HALF) begin
                     if (cur_row_ff == row_end) begin
                        mode_in = clr_pkg::MODE_IDLE;
                        fail    = 1'b1;
                     end else begin
                        hit        = 1'b1;
                        cur_row_in = row_step;
                        err_acc_in = err_sub;
                     end
                  end else begin
                     cur_col_in = col_step;
                     mode_in    = clr_pkg::MODE_COL;
                     if (g_ff == 2'd3) begin
                        fail = 1'b1;
                     end else begin
                        g_in = g_ff + 2'd1;
                     end
                  end
               end
               default: begin
                  fail = 1'b1;
               end
            endcase

            if (fail) begin
               drawing_in = 1'b0;
               fin        = 1'b1;
            end else if (hit) begin
               // Skip a write that repeats the last pixel handed out.
               if (key != last_ff) begin
                  last_in     = key;
                  pend_col_in = cur_col_ff;
                  pend_row_in = cur_row_ff;
                  drawing_in  = 1'b1;
                  fin         = 1'b1;
               end else if (k_ff == 2'd3) begin
                  drawing_in = 1'b0;
                  fin        = 1'b1;
               end else begin
                  k_in = k_ff + 2'd1;
                  g_in = 2'd0;
               end
            end
            if (fin) begin
               res_in.line_done = !drawing_in;
               bstate_in        = B_OUT;
            end
         end
         B_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load      = 1'b1;
               bstate_in = B_IDLE;
            end
         end
         default: begin
            bstate_in = B_IDLE;
         end
      endcase

      rsp_in       = load ? res_ff : rsp_ff;
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bstate_ff    <= B_IDLE;
         mode_ff      <= clr_pkg::MODE_IDLE;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         stop_col_ff  <= '0;
         stop_row_ff  <= '0;
         col_dir_ff   <= '0;
         row_dir_ff   <= '0;
         err_acc_ff   <= '0;
         err_step_ff  <= '0;
         color_ff     <= '0;
         last_ff      <= '1;
         pend_col_ff  <= '0;
         pend_row_ff  <= '0;
         drawing_ff   <= 1'b0;
         k_ff         <= '0;
         g_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bstate_ff    <= bstate_in;
         mode_ff      <= mode_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         stop_col_ff  <= stop_col_in;
         stop_row_ff  <= stop_row_in;
         col_dir_ff   <= col_dir_in;
         row_dir_ff   <= row_dir_in;
         err_acc_ff   <= err_acc_in;
         err_step_ff  <= err_step_in;
         color_ff     <= color_in;
         last_ff      <= last_in;
         pend_col_ff  <= pend_col_in;
         pend_row_ff  <= pend_row_in;
         drawing_ff   <= drawing_in;
         k_ff         <= k_in;
         g_ff         <= g_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/clipped_line_rasterizer.sv =====
// Steps go through the back end one at a time. A step with no pixel pending goes from the queue
// straight into the output register; otherwise it leaves the queue, walks (a repeated pixel and
// a column move each add a walk iteration) and then goes into the output register. A start
// request holds the front end for up to five passes of the shared divider plus the rounding
// multiplies. Reset is synchronous: it idles both sides, empties the queue and restores the
// full screen.
module clipped_line_rasterizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  clr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output clr_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [8:0]       csr_wr_data
);

   clr_pkg::cfg_type cfg_ff;
   logic             q_push, q_pop, q_full, q_empty;
   clr_pkg::cmd_type push_cmd, head_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clip_left   <= '0;
         cfg_ff.clip_top    <= '0;
         cfg_ff.clip_right  <= 9'(clr_pkg::SCREEN_W);
         cfg_ff.clip_bottom <= 8'(clr_pkg::SCREEN_H);
      end else if (csr_wr_en) begin
         case (csr_index)
            clr_pkg::CSR_CLIP_LEFT:   cfg_ff.clip_left   <= csr_wr_data;
            clr_pkg::CSR_CLIP_TOP:    cfg_ff.clip_top    <= csr_wr_data[7:0];
            clr_pkg::CSR_CLIP_RIGHT:  cfg_ff.clip_right  <= csr_wr_data;
            clr_pkg::CSR_CLIP_BOTTOM: cfg_ff.clip_bottom <= csr_wr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   clr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_push    (q_push),
      .q_cmd     (push_cmd),
      .q_full    (q_full)
   );

   clr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   clr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_cmd     (head_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("command pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("command popped from an empty queue");

   a_blank_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.pixel_valid) |->
         (rsp_data.pixel_color == '0 && rsp_data.pixel_address == '0))
      else $error("result without a pixel carries pixel data");
`endif

endmodule

// ===== bench/clipped_line_rasterizer_tb.sv =====
`timescale 1ns / 1ps

module clipped_line_rasterizer_tb;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   clr_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   clr_pkg::rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [8:0] csr_wr_data = '0;

   clipped_line_rasterizer u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the clip registers and the line walker.
   int       win_left, win_top, win_right, win_bottom;
   bit       px_pending;
   clr_pkg::mode_type walk_mode;
   int       cur_col, cur_row, stop_col, stop_row, col_dir, row_dir;
   longint   err_acc, err_step;
   logic [23:0] line_color, last_pixel_key;
   int       pend_col, pend_row;

   clr_pkg::rsp_type pixel_queue[$];
   bit       calm = 1'b0;
   int       error_count = 0;
   int       sent_count = 0;
   int       pixel_count = 0;
   int       line_count = 0;
   int       stall_cycles = 0;

   function automatic longint floor_div(longint a, longint b);
      longint q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint q16_ratio(longint q, longint p);
      longint num = q * 65536;
      longint den = p;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      return floor_div(2 * num + den, 2 * den);
   endfunction

   function automatic int sign_of(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   function automatic int clamp(int v, int lo, int hi);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v;
   endfunction

   function automatic void set_straight(int c0, int r0, int c1, int r1);
      cur_col = c0; cur_row = r0; stop_col = c1; stop_row = r1;
      col_dir = sign_of(c1 - c0);
      row_dir = sign_of(r1 - r0);
      walk_mode = clr_pkg::MODE_STRAIGHT;
   endfunction

   function automatic void setup_line(int x0, int y0, int x1, int y1);
      longint dx, dy, t0, t1, rq;
      longint p[4], q[4];
      int rx0, ry0, rx1, ry1;
      t0 = 0;
      t1 = 65536;
      if (win_left >= win_right || win_top >= win_bottom) return;
      x0 += win_left; x1 += win_left; y0 += win_top; y1 += win_top;
      if (x0 == x1) begin
         if (x0 < win_left || x0 >= win_right) return;
         set_straight(x0, clamp(y0, win_top, win_bottom - 1),
                      x0, clamp(y1, win_top, win_bottom - 1));
         return;
      end
      if (y0 == y1) begin
         if (y0 < win_top || y0 >= win_bottom) return;
         set_straight(clamp(x0, win_left, win_right - 1), y0,
                      clamp(x1, win_left, win_right - 1), y0);
         return;
      end
      dx = x1 - x0;
      dy = y1 - y0;
      p[0] = -dx; q[0] = x0 - win_left;
      p[1] = dx;  q[1] = win_right - 1 - x0;
      p[2] = -dy; q[2] = y0 - win_top;
      p[3] = dy;  q[3] = win_bottom - 1 - y0;
      for (int i = 0; i < 4; i++) begin
         rq = q16_ratio(q[i], p[i]);
         if (p[i] < 0) begin
            if (rq > t1) return;
            if (rq > t0) t0 = rq;
         end else begin
            if (rq < t0) return;
            if (rq < t1) t1 = rq;
         end
      end
      rx0 = int'(floor_div(longint'(x0) * 65536 + t0 * dx + 32768, 65536));
      ry0 = int'(floor_div(longint'(y0) * 65536 + t0 * dy + 32768, 65536));
      rx1 = int'(floor_div(longint'(x0) * 65536 + t1 * dx + 32768, 65536));
      ry1 = int'(floor_div(longint'(y0) * 65536 + t1 * dy + 32768, 65536));
      dx = rx1 - rx0;
      dy = ry1 - ry0;
      if (dx == 0) return;
      err_step = ((dy < 0 ? -dy : dy) * 65536) / (dx < 0 ? -dx : dx);
      err_acc = 0;
      col_dir = sign_of(dx);
      row_dir = sign_of(dy);
      cur_col = rx0; cur_row = ry0; stop_col = rx1; stop_row = ry1;
      walk_mode = clr_pkg::MODE_COL;
   endfunction

   function automatic bit next_write(output int c, output int r);
      c = 0;
      r = 0;
      for (int guard = 0; guard < 4; guard++) begin
         case (walk_mode)
            clr_pkg::MODE_STRAIGHT: begin
               c = cur_col; r = cur_row;
               if (cur_col == stop_col && cur_row == stop_row) walk_mode = clr_pkg::MODE_IDLE;
               else begin
                  cur_col += col_dir;
                  cur_row += row_dir;
               end
               return 1'b1;
            end
            clr_pkg::MODE_COL: begin
               if (cur_col == stop_col + col_dir) begin
                  walk_mode = clr_pkg::MODE_IDLE;
                  return 1'b0;
               end
               c = cur_col; r = cur_row;
               err_acc += err_step;
               walk_mode = clr_pkg::MODE_ROW;
               return 1'b1;
            end
            clr_pkg::MODE_ROW: begin
               if (err_acc >= 32768) begin
                  if (cur_row == stop_row + row_dir) begin
                     walk_mode = clr_pkg::MODE_IDLE;
                     return 1'b0;
                  end
                  c = cur_col; r = cur_row;
                  cur_row += row_dir;
                  err_acc -= 65536;
                  return 1'b1;
               end
               cur_col += col_dir;
               walk_mode = clr_pkg::MODE_COL;
            end
            default: return 1'b0;
         endcase
      end
      return 1'b0;
   endfunction

   // Repeated writes of the same pixel are skipped, at most four per step.
   function automatic void find_next_pixel();
      int c, r;
      logic [23:0] key;
      px_pending = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (!next_write(c, r)) return;
         key = {c[11:0], r[11:0]};
         if (key != last_pixel_key) begin
            last_pixel_key = key;
            pend_col = c;
            pend_row = r;
            px_pending = 1'b1;
            return;
         end
      end
   endfunction

   function automatic clr_pkg::rsp_type predict_pixel(clr_pkg::req_type r);
      clr_pkg::rsp_type res = '0;
      int addr;
      if (r.kind == clr_pkg::KIND_START) begin
         px_pending = 1'b0;
         walk_mode = clr_pkg::MODE_IDLE;
         err_acc = 0;
         err_step = 0;
         last_pixel_key = '1;
         line_color = r.color;
         setup_line(int'($signed(r.x_start)), int'($signed(r.y_start)),
                    int'($signed(r.x_end)), int'($signed(r.y_end)));
         find_next_pixel();
         res.line_done = !px_pending;
         return res;
      end
      if (!px_pending) begin
         res.line_done = 1'b1;
         return res;
      end
      addr = pend_row * clr_pkg::SCREEN_W + pend_col;
      res.pixel_valid = 1'b1;
      res.pixel_x = pend_col[8:0];
      res.pixel_y = pend_row[7:0];
      res.pixel_address = addr[15:0];
      res.pixel_color = line_color;
      find_next_pixel();
      res.line_done = !px_pending;
      return res;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         pixel_queue.push_back(predict_pixel(req_data));
         sent_count++;
      end
   end

   always @(posedge clock) begin
      clr_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_queue.size() == 0) begin
            $error("result with nothing expected: %h", rsp_data);
            error_count++;
         end else begin
            exp_rsp = pixel_queue.pop_front();
            if (exp_rsp.pixel_valid) pixel_count++;
            if (rsp_data.pixel_valid !== exp_rsp.pixel_valid) begin
               $error("pixel_valid expected %0d got %0d", exp_rsp.pixel_valid,
                      rsp_data.pixel_valid);
               error_count++;
            end
            if (rsp_data.pixel_x !== exp_rsp.pixel_x) begin
               $error("pixel_x expected %0d got %0d", exp_rsp.pixel_x, rsp_data.pixel_x);
               error_count++;
            end
            if (rsp_data.pixel_y !== exp_rsp.pixel_y) begin
               $error("pixel_y expected %0d got %0d", exp_rsp.pixel_y, rsp_data.pixel_y);
               error_count++;
            end
            if (rsp_data.pixel_address !== exp_rsp.pixel_address) begin
               $error("pixel_address expected %0d got %0d", exp_rsp.pixel_address,
                      rsp_data.pixel_address);
               error_count++;
            end
            if (rsp_data.pixel_color !== exp_rsp.pixel_color) begin
               $error("pixel_color expected %h got %h", exp_rsp.pixel_color,
                      rsp_data.pixel_color);
               error_count++;
            end
            if (rsp_data.line_done !== exp_rsp.line_done) begin
               $error("line_done expected %0d got %0d", exp_rsp.line_done,
                      rsp_data.line_done);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 24);
   end

   // A start request can hold the block while it clips the line; the watchdog allows for that.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= 20000) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Called at a clock edge; returns at the edge where the request is accepted.
   task automatic send_request(clr_pkg::req_type r);
      if (!calm && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 40);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_start(int x0, int y0, int x1, int y1, logic [23:0] color);
      clr_pkg::req_type r;
      r.kind = clr_pkg::KIND_START;
      r.x_start = x0[11:0];
      r.y_start = y0[11:0];
      r.x_end = x1[11:0];
      r.y_end = y1[11:0];
      r.color = color;
      send_request(r);
      line_count++;
   endtask

   task automatic send_steps(int n);
      clr_pkg::req_type r;
      for (int i = 0; i < n; i++) begin
         r = clr_pkg::req_type'(73'({$urandom, $urandom, $urandom}));
         r.kind = clr_pkg::KIND_STEP;
         send_request(r);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pixel_queue.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_clip(int left, int top, int right, int bottom);
      int vals[4];
      vals = '{left, top, right, bottom};
      drain();
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= clr_pkg::csr_index_type'(i);
         csr_wr_data <= vals[i][8:0];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      win_left = left & 9'h1FF;
      win_top = top & 8'hFF;
      win_right = right & 9'h1FF;
      win_bottom = bottom & 8'hFF;
      @(posedge clock);
   endtask

   task automatic test_straight_lines();
      send_steps(1);
      send_start(5, 5, 5, 5, 24'hFFFFFF);
      send_steps(2);
      send_start(10, -30, 10, 400, 24'h000000);
      send_steps(6);
      send_start(-50, 7, 2047, 7, 24'h123456);
      send_steps(4);
      send_start(-3, 0, -3, 20, 24'hABCDEF);
      send_steps(1);
      send_start(0, 250, 30, 250, 24'h55AA55);
      send_steps(1);
   endtask

   task automatic test_clipped_diagonals();
      send_start(-2048, -2048, 2047, 2047, 24'h800001);
      send_steps(5);
      send_start(3, 1, 20, 9, 24'h0F0F0F);
      send_steps(20);
      send_start(40, 30, 38, 1, 24'hF0F0F0);
      send_steps(32);
      send_start(-100, 50, 100, -2000, 24'h777777);
      send_steps(3);
      // Steep line whose clipped x span rounds to nothing.
      send_start(0, -1000, 1, 1000, 24'h010203);
      send_steps(2);
      send_start(2047, -2048, -2048, 2047, 24'h3C3C3C);
      send_steps(4);
   endtask

   task automatic random_lines(int target, int spread);
      int x0, y0, x1, y1, span, roll;
      int start_sent;
      start_sent = sent_count;
      while (sent_count - start_sent < target) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            x0 = $signed(12'($urandom)); y0 = $signed(12'($urandom));
            x1 = $signed(12'($urandom)); y1 = $signed(12'($urandom));
         end else begin
            x0 = $urandom_range(0, spread) - 10; y0 = $urandom_range(0, spread) - 10;
            x1 = $urandom_range(0, spread) - 10; y1 = $urandom_range(0, spread) - 10;
            if (roll < 20) x1 = x0;
            else if (roll < 30) y1 = y0;
         end
         send_start(x0, y0, x1, y1, 24'($urandom));
         span = (x1 > x0 ? x1 - x0 : x0 - x1);
         if ((y1 > y0 ? y1 - y0 : y0 - y1) > span) span = (y1 > y0 ? y1 - y0 : y0 - y1);
         if (span > 60) span = 60;
         // Some lines are cut short by the next start, some overrun into idle steps.
         if ($urandom_range(0, 99) < 15) send_steps($urandom_range(0, span));
         else send_steps(span + $urandom_range(0, 3));
      end
   endtask

   task automatic test_window_settings();
      write_clip(10, 5, 50, 40);
      random_lines(300, 60);
      write_clip(0, 0, 511, 255);
      random_lines(200, 80);
      write_clip(320, 0, 320, 200);
      random_lines(60, 40);
      write_clip(100, 199, 300, 199);
      random_lines(40, 40);
      write_clip(300, 180, 320, 200);
      calm = 1'b1;
      random_lines(250, 35);
      calm = 1'b0;
      write_clip(0, 0, 320, 200);
      random_lines(650, 50);
   endtask

   initial begin
      win_left = 0;
      win_top = 0;
      win_right = clr_pkg::SCREEN_W;
      win_bottom = clr_pkg::SCREEN_H;
      px_pending = 1'b0;
      walk_mode = clr_pkg::MODE_IDLE;
      last_pixel_key = '1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_straight_lines();
      test_clipped_diagonals();
      test_window_settings();
      drain();
      $display("Sent %0d requests over %0d lines and checked %0d drawn pixels,",
               sent_count, line_count, pixel_count);
      $display("across default, inner, oversized, empty and corner clip windows.");
      if (error_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
